FILE: rtl/v3alu_pkg.sv
// Shared types and constants for the three-component vector ALU.
// No dependencies; imported by every module of the block.
package v3alu_pkg;

    localparam int LANES      = 3;
    localparam int FIELD_W    = 32;
    localparam int OPCODE_W   = 4;
    localparam int IN_DATA_W  = 6 * FIELD_W;
    localparam int OUT_DATA_W = 3 * FIELD_W;
    localparam int OUT_USER_W = 3;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ADD    = 4'd0,
        OP_SUB    = 4'd1,
        OP_MUL    = 4'd2,
        OP_DIV    = 4'd3,
        OP_DOT    = 4'd4,
        OP_CROSS  = 4'd5,
        OP_LENGTH = 4'd6,
        OP_NORM   = 4'd7,
        OP_EQUAL  = 4'd8
    } opcode_t;

    typedef enum logic [1:0] {
        LM_ADD  = 2'd0,
        LM_SUB  = 2'd1,
        LM_PROD = 2'd2,
        LM_DIFF = 2'd3
    } lane_mode_t;

    typedef struct packed {
        logic [FIELD_W-1:0] r_z;
        logic [FIELD_W-1:0] r_y;
        logic [FIELD_W-1:0] r_x;
        logic               divide_by_zero;
        logic               saturated;
        logic               equal_flag;
    } res_t;

endpackage

FILE: rtl/v3alu_pipe.sv
// Enabled delay line that carries shared sideband alongside the divider lanes.
// Depends on v3alu_pkg.
module v3alu_pipe #(
    parameter int DEPTH = 48,
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [WIDTH-1:0] d_in,
    output logic [WIDTH-1:0] d_out
);
    import v3alu_pkg::*;

    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            tap_reg[0] <= d_in;
            for (int k = 1; k < DEPTH; k++) begin
                tap_reg[k] <= tap_reg[k-1];
            end
        end
    end

    assign d_out = tap_reg[DEPTH-1];

endmodule

FILE: rtl/v3alu_lane.sv
// One arithmetic lane: two products and an add/subtract, then a combine stage.
// Depends on v3alu_pkg (lane_mode_t).
module v3alu_lane #(
    parameter int WORD_BITS = 32
) (
    input  logic                            aclk,
    input  logic                            en,
    input  v3alu_pkg::lane_mode_t           mode,
    input  logic signed [WORD_BITS-1:0]     x1,
    input  logic signed [WORD_BITS-1:0]     y1,
    input  logic signed [WORD_BITS-1:0]     x2,
    input  logic signed [WORD_BITS-1:0]     y2,
    output logic signed [2*WORD_BITS:0]     s_out
);
    import v3alu_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int AW = W + 1;
    localparam int LW = 2 * W + 1;

    logic signed [2*W-1:0] p1_reg, p2_reg;
    logic signed [AW-1:0]  as_reg;
    lane_mode_t            mode_reg;
    logic signed [LW-1:0]  s_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg   <= x1 * y1;
            p2_reg   <= x2 * y2;
            as_reg   <= (mode == LM_SUB) ? AW'(x1) - AW'(x2) : AW'(x1) + AW'(x2);
            mode_reg <= mode;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            unique case (mode_reg)
                LM_ADD, LM_SUB: s_reg <= LW'(as_reg);
                LM_PROD:        s_reg <= LW'(p1_reg);
                LM_DIFF:        s_reg <= LW'(p1_reg) - LW'(p2_reg);
                default:        s_reg <= '0;
            endcase
        end
    end

    assign s_out = s_reg;

endmodule

FILE: rtl/v3alu_isqrt.sv
// Pipelined integer square root, one result bit per stage, with sideband.
// Depends on v3alu_pkg.
module v3alu_isqrt #(
    parameter int WORD_BITS = 32,
    parameter int SIDE_W    = 8
) (
    input  logic                   aclk,
    input  logic                   en,
    input  logic [2*WORD_BITS-1:0] rad_in,
    input  logic [SIDE_W-1:0]      side_in,
    output logic [WORD_BITS-1:0]   root_out,
    output logic [SIDE_W-1:0]      side_out
);
    import v3alu_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int RW = W + 3;

    logic [RW-1:0]     rem_reg  [W];
    logic [W-1:0]      root_reg [W];
    logic [2*W-1:0]    rad_reg  [W];
    logic [SIDE_W-1:0] side_reg [W];

    for (genvar k = 0; k < W; k++) begin : g_stage
        logic [RW-1:0]     rem_i, rem_t, trial;
        logic [W-1:0]      root_i;
        logic [2*W-1:0]    rad_i;
        logic [SIDE_W-1:0] side_i;
        logic              take;

        if (k == 0) begin : g_first
            assign rem_i  = '0;
            assign root_i = '0;
            assign rad_i  = rad_in;
            assign side_i = side_in;
        end else begin : g_next
            assign rem_i  = rem_reg[k-1];
            assign root_i = root_reg[k-1];
            assign rad_i  = rad_reg[k-1];
            assign side_i = side_reg[k-1];
        end

        assign rem_t = {rem_i[RW-3:0], rad_i[2*W-1 -: 2]};
        assign trial = {1'b0, root_i, 2'b01};
        assign take  = (rem_t >= trial);

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= take ? rem_t - trial : rem_t;
                root_reg[k] <= {root_i[W-2:0], take};
                rad_reg[k]  <= {rad_i[2*W-3:0], 2'b00};
                side_reg[k] <= side_i;
            end
        end
    end

    assign root_out = root_reg[W-1];
    assign side_out = side_reg[W-1];

endmodule

FILE: rtl/v3alu_div.sv
// Pipelined restoring divider for one lane, one quotient bit per stage.
// Depends on v3alu_pkg.
module v3alu_div #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16,
    parameter int SIDE_W    = 8
) (
    input  logic                           aclk,
    input  logic                           en,
    input  logic [WORD_BITS+FRAC_BITS-1:0] num_in,
    input  logic [WORD_BITS-1:0]           den_in,
    input  logic [SIDE_W-1:0]              side_in,
    output logic [WORD_BITS+FRAC_BITS-1:0] quo_out,
    output logic [SIDE_W-1:0]              side_out
);
    import v3alu_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int NB = WORD_BITS + FRAC_BITS;

    logic [W-1:0]      rem_reg  [NB];
    logic [NB-1:0]     nq_reg   [NB];
    logic [W-1:0]      den_reg  [NB];
    logic [SIDE_W-1:0] side_reg [NB];

    for (genvar k = 0; k < NB; k++) begin : g_stage
        logic [W-1:0]      rem_i, den_i;
        logic [NB-1:0]     nq_i;
        logic [SIDE_W-1:0] side_i;
        logic [W:0]        rt, dif;
        logic              take;

        if (k == 0) begin : g_first
            assign rem_i  = '0;
            assign nq_i   = num_in;
            assign den_i  = den_in;
            assign side_i = side_in;
        end else begin : g_next
            assign rem_i  = rem_reg[k-1];
            assign nq_i   = nq_reg[k-1];
            assign den_i  = den_reg[k-1];
            assign side_i = side_reg[k-1];
        end

        assign rt   = {rem_i, nq_i[NB-1]};
        assign dif  = rt - {1'b0, den_i};
        assign take = (rt >= {1'b0, den_i});

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= take ? dif[W-1:0] : rt[W-1:0];
                nq_reg[k]   <= {nq_i[NB-2:0], take};
                den_reg[k]  <= den_i;
                side_reg[k] <= side_i;
            end
        end
    end

    assign quo_out  = nq_reg[NB-1];
    assign side_out = side_reg[NB-1];

endmodule

FILE: rtl/vec3_arithmetic_unit.sv
// Three-component fixed-point vector ALU, top level.
// Depends on v3alu_pkg, v3alu_lane, v3alu_isqrt, v3alu_div and v3alu_pipe.
//
// Usage:
//   s_ side takes one word per item: the opcode in s_tuser, the two vectors
//   a and b in s_tdata. m_ side returns one word per item: r_x, r_y, r_z in
//   m_tdata and equal_flag, saturated, divide_by_zero in m_tuser.
//   Throughput is one item per cycle for every opcode, except while the
//   pipeline is halted by the output stall below. Three lanes (one per
//   component) run the products, then a square-root pipeline and three
//   divider pipelines follow, which every item passes through. On its way
//   to m_tvalid an item passes the front stages, the square-root stages (one
//   root bit each), the divider stages (one quotient bit each) and the buffer.
//   Results enter a two-word output buffer; the pipeline keeps accepting while
//   one result waits and halts only when both entries are full and m_tready
//   is low. Nothing is lost or repeated under stalls on either side.
//   Reset (aresetn low, synchronous) empties the pipeline and the buffer;
//   s_tready is high right after reset.
module vec3_arithmetic_unit #(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [v3alu_pkg::IN_DATA_W-1:0]  s_tdata,  // a_x, a_y, a_z, b_x, b_y, b_z
    input  logic [v3alu_pkg::OPCODE_W-1:0]   s_tuser,  // opcode
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [v3alu_pkg::OUT_DATA_W-1:0] m_tdata,  // r_x, r_y, r_z
    output logic [v3alu_pkg::OUT_USER_W-1:0] m_tuser   // equal_flag, saturated, divide_by_zero
);
    import v3alu_pkg::*;

    localparam int W     = WORD_BITS;
    localparam int F     = FRAC_BITS;
    localparam int LW    = 2 * W + 1;
    localparam int DW    = 2 * W + 3;
    localparam int NB    = W + F;
    localparam int BW    = DW + NB;
    localparam int LAT   = 3 + W + NB;
    localparam int SQ_W  = OPCODE_W + 6 * W + 3 * LW + DW;
    localparam int CM_W  = OPCODE_W + DW + W;
    localparam int LS_W  = 2 * W + LW;

    localparam logic signed [BW-1:0] MAXV = $signed({{(BW-W+1){1'b0}}, {(W-1){1'b1}}});
    localparam logic signed [BW-1:0] MINV = $signed({{(BW-W+1){1'b1}}, {(W-1){1'b0}}});
    localparam logic signed [BW-1:0] RND  = $signed({{(BW-F){1'b0}}, {F{1'b1}}});

    function automatic logic signed [BW-1:0] trunc_frac(input logic signed [BW-1:0] v);
        logic signed [BW-1:0] biased;
        biased = v[BW-1] ? v + RND : v;
        return biased >>> F;
    endfunction

    function automatic logic [W:0] sat_word(input logic signed [BW-1:0] v);
        logic [W:0] r;
        if (v > MAXV) begin
            r = {1'b1, MAXV[W-1:0]};
        end else if (v < MINV) begin
            r = {1'b1, MINV[W-1:0]};
        end else begin
            r = {1'b0, v[W-1:0]};
        end
        return r;
    endfunction

    logic pipe_en;
    logic push, pop;

    // input decode and lanes
    opcode_t              in_op;
    logic signed [W-1:0]  in_a [LANES];
    logic signed [W-1:0]  in_b [LANES];
    lane_mode_t           ln_mode [LANES];
    logic signed [W-1:0]  ln_x1 [LANES];
    logic signed [W-1:0]  ln_y1 [LANES];
    logic signed [W-1:0]  ln_x2 [LANES];
    logic signed [W-1:0]  ln_y2 [LANES];
    logic signed [LW-1:0] ln_s  [LANES];

    assign in_op    = opcode_t'(s_tuser);
    assign s_tready = pipe_en;

    for (genvar i = 0; i < LANES; i++) begin : g_lane
        logic [FIELD_W-1:0] raw_a, raw_b;

        assign raw_a = s_tdata[FIELD_W*i +: FIELD_W];
        assign raw_b = s_tdata[FIELD_W*(LANES+i) +: FIELD_W];

        if (W > FIELD_W) begin : g_wide
            assign in_a[i] = $signed({{(W-FIELD_W){1'b0}}, raw_a});
            assign in_b[i] = $signed({{(W-FIELD_W){1'b0}}, raw_b});
        end else begin : g_narrow
            assign in_a[i] = $signed(raw_a[W-1:0]);
            assign in_b[i] = $signed(raw_b[W-1:0]);
        end
    end

    for (genvar i = 0; i < LANES; i++) begin : g_opnd
        localparam int J = (i + 1) % LANES;
        localparam int K = (i + 2) % LANES;

        always_comb begin
            ln_mode[i] = LM_PROD;
            ln_x1[i]   = in_a[i];
            ln_y1[i]   = in_b[i];
            ln_x2[i]   = in_b[i];
            ln_y2[i]   = '0;
            unique case (in_op)
                OP_ADD: ln_mode[i] = LM_ADD;
                OP_SUB: ln_mode[i] = LM_SUB;
                OP_CROSS: begin
                    ln_mode[i] = LM_DIFF;
                    ln_x1[i]   = in_a[J];
                    ln_y1[i]   = in_b[K];
                    ln_x2[i]   = in_a[K];
                    ln_y2[i]   = in_b[J];
                end
                OP_LENGTH, OP_NORM: ln_y1[i] = in_a[i];
                default: ;
            endcase
        end

        v3alu_lane #(.WORD_BITS(W)) u_lane (
            .aclk  (aclk),
            .en    (pipe_en),
            .mode  (ln_mode[i]),
            .x1    (ln_x1[i]),
            .y1    (ln_y1[i]),
            .x2    (ln_x2[i]),
            .y2    (ln_y2[i]),
            .s_out (ln_s[i])
        );
    end

    // front stages
    logic [LAT-1:0]       vld_reg;
    opcode_t              st1_op_reg, st2_op_reg, st3_op_reg;
    logic signed [W-1:0]  st1_a_reg [LANES];
    logic signed [W-1:0]  st1_b_reg [LANES];
    logic signed [W-1:0]  st2_a_reg [LANES];
    logic signed [W-1:0]  st2_b_reg [LANES];
    logic signed [W-1:0]  st3_a_reg [LANES];
    logic signed [W-1:0]  st3_b_reg [LANES];
    logic signed [LW-1:0] st3_s_reg [LANES];
    logic signed [DW-1:0] st3_sum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (pipe_en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            st1_op_reg  <= in_op;
            st2_op_reg  <= st1_op_reg;
            st3_op_reg  <= st2_op_reg;
            st3_sum_reg <= DW'(ln_s[0]) + DW'(ln_s[1]) + DW'(ln_s[2]);
            for (int i = 0; i < LANES; i++) begin
                st1_a_reg[i] <= in_a[i];
                st1_b_reg[i] <= in_b[i];
                st2_a_reg[i] <= st1_a_reg[i];
                st2_b_reg[i] <= st1_b_reg[i];
                st3_a_reg[i] <= st2_a_reg[i];
                st3_b_reg[i] <= st2_b_reg[i];
                st3_s_reg[i] <= ln_s[i];
            end
        end
    end

    // square root
    logic [SQ_W-1:0]      sq_side_in, sq_side_out;
    logic [W-1:0]         sq_root;
    opcode_t              q_op;
    logic signed [DW-1:0] q_sum;
    logic signed [W-1:0]  q_a [LANES];
    logic signed [W-1:0]  q_b [LANES];
    logic signed [LW-1:0] q_s [LANES];

    assign sq_side_in = {st3_op_reg, st3_a_reg[2], st3_a_reg[1], st3_a_reg[0],
                         st3_b_reg[2], st3_b_reg[1], st3_b_reg[0],
                         st3_s_reg[2], st3_s_reg[1], st3_s_reg[0], st3_sum_reg};

    v3alu_isqrt #(.WORD_BITS(W), .SIDE_W(SQ_W)) u_isqrt (
        .aclk     (aclk),
        .en       (pipe_en),
        .rad_in   (st3_sum_reg[2*W-1:0]),
        .side_in  (sq_side_in),
        .root_out (sq_root),
        .side_out (sq_side_out)
    );

    assign q_op  = opcode_t'(sq_side_out[SQ_W-1 -: OPCODE_W]);
    assign q_sum = $signed(sq_side_out[DW-1:0]);

    // divider lanes and shared sideband
    logic [CM_W-1:0]      cm_out;
    opcode_t              f_op;
    logic signed [DW-1:0] f_sum;
    logic [W-1:0]         f_root;
    logic [NB-1:0]        f_q [LANES];
    logic signed [W-1:0]  f_a [LANES];
    logic signed [W-1:0]  f_b [LANES];
    logic signed [LW-1:0] f_s [LANES];

    v3alu_pipe #(.DEPTH(NB), .WIDTH(CM_W)) u_pipe (
        .aclk  (aclk),
        .en    (pipe_en),
        .d_in  ({q_op, q_sum, sq_root}),
        .d_out (cm_out)
    );

    assign f_op   = opcode_t'(cm_out[CM_W-1 -: OPCODE_W]);
    assign f_sum  = $signed(cm_out[W +: DW]);
    assign f_root = cm_out[W-1:0];

    for (genvar i = 0; i < LANES; i++) begin : g_div
        logic [W-1:0]    mag_a, mag_b, den;
        logic [NB-1:0]   num;
        logic [LS_W-1:0] ls_out;

        assign q_s[i] = $signed(sq_side_out[DW + i*LW +: LW]);
        assign q_b[i] = $signed(sq_side_out[DW + 3*LW + i*W +: W]);
        assign q_a[i] = $signed(sq_side_out[DW + 3*LW + 3*W + i*W +: W]);

        assign mag_a = q_a[i][W-1] ? W'(-q_a[i]) : q_a[i];
        assign mag_b = q_b[i][W-1] ? W'(-q_b[i]) : q_b[i];
        assign num   = {mag_a, {F{1'b0}}};
        assign den   = (q_op == OP_NORM) ? sq_root : mag_b;

        v3alu_div #(.WORD_BITS(W), .FRAC_BITS(F), .SIDE_W(LS_W)) u_div (
            .aclk     (aclk),
            .en       (pipe_en),
            .num_in   (num),
            .den_in   (den),
            .side_in  ({q_a[i], q_b[i], q_s[i]}),
            .quo_out  (f_q[i]),
            .side_out (ls_out)
        );

        assign f_s[i] = $signed(ls_out[LW-1:0]);
        assign f_b[i] = $signed(ls_out[LW +: W]);
        assign f_a[i] = $signed(ls_out[LW + W +: W]);
    end

    // merge: per-component result, clamp and flags
    logic [FIELD_W-1:0] out_word [LANES];
    logic [LANES-1:0]   lane_sat, lane_dz;
    logic               eq_flag;
    res_t               push_word;

    for (genvar i = 0; i < LANES; i++) begin : g_out
        logic signed [BW-1:0] val, q_ext;
        logic                 act, frc, dzf, a_neg, b_neg;
        logic [W-1:0]         frc_word, word;
        logic [W:0]           sw;

        assign q_ext = $signed({{(BW-NB){1'b0}}, f_q[i]});
        assign a_neg = f_a[i][W-1];
        assign b_neg = f_b[i][W-1];

        always_comb begin
            act      = 1'b0;
            frc      = 1'b0;
            dzf      = 1'b0;
            frc_word = '0;
            val      = '0;
            unique case (f_op)
                OP_ADD, OP_SUB: begin
                    act = 1'b1;
                    val = BW'(f_s[i]);
                end
                OP_MUL, OP_CROSS: begin
                    act = 1'b1;
                    val = trunc_frac(BW'(f_s[i]));
                end
                OP_DOT: begin
                    if (i == 0) begin
                        act = 1'b1;
                        val = trunc_frac(BW'(f_sum));
                    end
                end
                OP_LENGTH: begin
                    if (i == 0) begin
                        act = 1'b1;
                        val = $signed({{(BW-W){1'b0}}, f_root});
                    end
                end
                OP_DIV: begin
                    if (f_b[i] == '0) begin
                        frc      = 1'b1;
                        dzf      = 1'b1;
                        frc_word = a_neg ? MINV[W-1:0] : MAXV[W-1:0];
                    end else begin
                        act = 1'b1;
                        val = (a_neg ^ b_neg) ? -q_ext : q_ext;
                    end
                end
                OP_NORM: begin
                    if (f_root == '0) begin
                        frc      = 1'b1;
                        frc_word = f_a[i];
                    end else begin
                        act = 1'b1;
                        val = a_neg ? -q_ext : q_ext;
                    end
                end
                default: ;
            endcase
        end

        assign sw          = sat_word(val);
        assign word        = frc ? frc_word : (act ? sw[W-1:0] : '0);
        assign lane_sat[i] = act & sw[W];
        assign lane_dz[i]  = dzf;

        if (W >= FIELD_W) begin : g_trim
            assign out_word[i] = word[FIELD_W-1:0];
        end else begin : g_sext
            assign out_word[i] = {{(FIELD_W-W){word[W-1]}}, word};
        end
    end

    assign eq_flag = (f_op == OP_EQUAL) && (f_a[0] == f_b[0]) &&
                     (f_a[1] == f_b[1]) && (f_a[2] == f_b[2]);

    assign push_word.r_x            = out_word[0];
    assign push_word.r_y            = out_word[1];
    assign push_word.r_z            = out_word[2];
    assign push_word.equal_flag     = eq_flag;
    assign push_word.saturated      = |lane_sat;
    assign push_word.divide_by_zero = |lane_dz;

    // output buffer
    logic [1:0] cnt_reg, cnt_next;
    logic       wr_ptr_reg, rd_ptr_reg;
    res_t       buf_reg [2];
    res_t       head;

    assign pipe_en  = (cnt_reg != 2'd2) || m_tready;
    assign push     = pipe_en && vld_reg[LAT-1];
    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = (cnt_reg != 2'd0);
    assign head     = buf_reg[rd_ptr_reg];
    assign m_tdata  = {head.r_z, head.r_y, head.r_x};
    assign m_tuser  = {head.divide_by_zero, head.saturated, head.equal_flag};

    always_comb begin
        unique case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= push_word;
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("output buffer count out of range");

    a_stall_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready && cnt_reg == 2'd2))
        else $error("input held off while buffer has room");

    a_equal_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0 && m_tuser[2:1] == 2'b00))
        else $error("equal result carries data or flags");
`endif

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for vec3_arithmetic_unit: directed and random words, random stalls
// on both stream sides, results checked against a local fixed-point vector predictor.
// Depends on v3alu_pkg and the vec3_arithmetic_unit RTL.
module tb;
    import v3alu_pkg::*;

    localparam logic signed [127:0] WMAX = 128'sd2147483647;
    localparam logic signed [127:0] WMIN = -128'sd2147483648;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [OPCODE_W-1:0]   s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;

    res_t result_q[$];
    int   mismatches = 0;
    bit   steady = 1'b0;

    vec3_arithmetic_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic logic [31:0] clamp(input logic signed [127:0] v, inout bit sat);
        if (v > WMAX) begin
            sat = 1'b1;
            return 32'h7fff_ffff;
        end
        if (v < WMIN) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic [127:0] isqrt(input logic [127:0] n);
        logic [127:0] res;
        logic [127:0] b;
        res = '0;
        b = 128'd1 << 126;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic res_t vec_result(input logic [3:0] op, input logic [IN_DATA_W-1:0] d);
        logic signed [127:0] a[3];
        logic signed [127:0] b[3];
        logic signed [127:0] v[3];
        logic signed [127:0] len;
        logic [31:0] r[3];
        bit sat, dz, eq, scal, live;
        res_t e;
        sat = 0; dz = 0; eq = 0; scal = 0; live = 1;
        for (int i = 0; i < 3; i++) begin
            a[i] = $signed(d[32*i +: 32]);
            b[i] = $signed(d[96+32*i +: 32]);
            v[i] = '0;
        end
        case (op)
            OP_ADD: for (int i = 0; i < 3; i++) v[i] = a[i] + b[i];
            OP_SUB: for (int i = 0; i < 3; i++) v[i] = a[i] - b[i];
            OP_MUL: for (int i = 0; i < 3; i++) v[i] = (a[i] * b[i]) / 65536;
            OP_DIV: for (int i = 0; i < 3; i++) begin
                if (b[i] == 0) begin
                    dz = 1;
                    v[i] = (a[i] < 0) ? WMIN : WMAX;
                end else begin
                    v[i] = (a[i] * 65536) / b[i];
                end
            end
            OP_DOT: begin
                v[0] = (a[0]*b[0] + a[1]*b[1] + a[2]*b[2]) / 65536;
                scal = 1;
            end
            OP_CROSS: begin
                v[0] = (a[1]*b[2] - a[2]*b[1]) / 65536;
                v[1] = (a[2]*b[0] - a[0]*b[2]) / 65536;
                v[2] = (a[0]*b[1] - a[1]*b[0]) / 65536;
            end
            OP_LENGTH, OP_NORM: begin
                len = $signed(isqrt(a[0]*a[0] + a[1]*a[1] + a[2]*a[2]));
                if (op == OP_LENGTH) begin
                    v[0] = len;
                    scal = 1;
                end else if (len == 0) begin
                    for (int i = 0; i < 3; i++) v[i] = a[i];
                end else begin
                    for (int i = 0; i < 3; i++) v[i] = (a[i] * 65536) / len;
                end
            end
            OP_EQUAL: begin
                eq = (a[0] == b[0]) && (a[1] == b[1]) && (a[2] == b[2]);
                live = 0;
            end
            default: live = 0;
        endcase
        for (int i = 0; i < 3; i++) begin
            if (!live || (scal && i > 0)) r[i] = '0;
            else r[i] = clamp(v[i], sat);
        end
        e.r_x = r[0];
        e.r_y = r[1];
        e.r_z = r[2];
        e.equal_flag = eq;
        e.saturated = sat;
        e.divide_by_zero = dz;
        return e;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t: %s got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    // predict on each accepted input word
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) result_q.push_back(vec_result(s_tuser, s_tdata));
    end

    // compare each accepted result word with the oldest prediction
    always @(posedge aclk) begin
        res_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = res_t'({m_tdata, m_tuser});
            if (result_q.size() == 0) begin
                report("unexpected word", m_tdata[31:0], 32'h0);
            end else begin
                want = result_q.pop_front();
                if (got.r_x !== want.r_x) report("r_x", got.r_x, want.r_x);
                if (got.r_y !== want.r_y) report("r_y", got.r_y, want.r_y);
                if (got.r_z !== want.r_z) report("r_z", got.r_z, want.r_z);
                if (got.equal_flag !== want.equal_flag)
                    report("equal_flag", got.equal_flag, want.equal_flag);
                if (got.saturated !== want.saturated)
                    report("saturated", got.saturated, want.saturated);
                if (got.divide_by_zero !== want.divide_by_zero)
                    report("divide_by_zero", got.divide_by_zero, want.divide_by_zero);
            end
        end
    end

    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= 30);
    end

    task automatic send_word(input logic [3:0] op, input logic [31:0] ax, ay, az, bx, by, bz);
        if (!steady && $urandom_range(99) < 30) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {bz, by, bx, az, ay, ax};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (result_q.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h0;
            1: return 32'h7fff_ffff;
            2: return 32'h8000_0000;
            3: return 32'h0001_0000;
            4: return 32'hffff_0000;
            5, 6: return $urandom_range(32'h0008_0000);
            7: return -$urandom_range(32'h0008_0000);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        logic [31:0] mx, mn;
        mx = 32'h7fff_ffff;
        mn = 32'h8000_0000;
        send_word(OP_ADD, mx, mn, 32'h0001_0000, 32'h1, 32'hffff_ffff, 32'hffff_0000);
        send_word(OP_ADD, mx, mn, mx, mx, mn, 32'h0);
        send_word(OP_SUB, mn, mx, 32'h0, 32'h1, 32'hffff_ffff, mn);
        send_word(OP_MUL, mx, mn, mn, mx, mn, mx);
        send_word(OP_MUL, 32'h0002_8000, 32'hfffe_8000, 32'h1, 32'h0001_0000, 32'h3, 32'h1);
        send_word(OP_DIV, 32'h0, 32'hffff_ffff, mx, 32'h0, 32'h0, 32'h0);
        send_word(OP_DIV, mx, mn, 32'h0003_0000, 32'h1, 32'h1, 32'hfffe_0000);
        send_word(OP_DIV, mn, 32'h0001_0000, 32'h7, 32'hffff_ffff, 32'h0, 32'h3);
        send_word(OP_DOT, mx, mx, mx, mx, mx, mx);
        send_word(OP_DOT, mn, mn, mn, mx, mx, mx);
        send_word(OP_CROSS, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0);
        send_word(OP_CROSS, mx, mn, mx, mn, mx, mn);
        send_word(OP_LENGTH, mn, mn, mn, 32'h0, 32'h0, 32'h0);
        send_word(OP_LENGTH, 32'h0003_0000, 32'h0004_0000, 32'h0, 32'h0, 32'h0, 32'h0);
        send_word(OP_NORM, 32'h0, 32'h0, 32'h0, mx, mx, mx);
        send_word(OP_NORM, 32'h0, 32'h0, 32'h1, 32'h0, 32'h0, 32'h0);
        send_word(OP_NORM, mn, 32'h0003_0000, mx, 32'h0, 32'h0, 32'h0);
        send_word(OP_EQUAL, mn, mx, 32'h5, mn, mx, 32'h5);
        send_word(OP_EQUAL, mn, mx, 32'h5, mn, mx, 32'h4);
        send_word(4'd9, mx, mx, mx, mx, mx, mx);
        send_word(4'd15, mn, mn, mn, mn, mn, mn);
    endtask

    task automatic test_random(input int n, input bit scalar_b);
        logic [31:0] a[3], b[3];
        logic [3:0] op;
        for (int k = 0; k < n; k++) begin
            op = ($urandom_range(19) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(8));
            foreach (a[i]) a[i] = pick_value();
            foreach (b[i]) b[i] = pick_value();
            if (scalar_b) begin
                b[1] = b[0];
                b[2] = b[0];
            end
            if (op == OP_EQUAL && $urandom_range(1)) begin
                b = a;
                if ($urandom_range(2) == 0) b[$urandom_range(2)][$urandom_range(31)] ^= 1'b1;
            end
            send_word(op, a[0], a[1], a[2], b[0], b[1], b[2]);
        end
    endtask

    task automatic test_no_idle(input int n);
        steady = 1'b1;
        test_random(n, 1'b0);
        steady = 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(400, 1'b0);
        drain();
        test_random(200, 1'b1);
        test_no_idle(250);
        test_random(400, 1'b0);
        drain();
        repeat (100) @(posedge aclk);
        if (mismatches == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
